// ===== rtl/core/hsfd_pkg.sv =====
package hsfd_pkg;

    // Frame layout: byte positions 0..5
    localparam logic [2:0] POS_TEMP_MSB = 3'd0;
    localparam logic [2:0] POS_TEMP_LSB = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_MSB  = 3'd3;
    localparam logic [2:0] POS_HUM_LSB  = 3'd4;
    localparam logic [2:0] POS_HUM_CRC  = 3'd5;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [14:0]        TEMP_SPAN_CENTI   = 15'd17500;
    localparam logic [13:0]        HUM_SPAN_CENTI    = 14'd10000;
    localparam logic signed [15:0] TEMP_OFFSET_CENTI = 16'sd4500;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TEMP_BAD = 2'd1,
        STATUS_HUM_BAD  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic [1:0]         frame_status;
    } t_out;

    // Complete frame handed from the front to the conversion side
    typedef struct packed {
        logic [15:0] raw_t;
        logic [15:0] raw_h;
        t_status     status;
    } t_frame;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/hsfd_stream_if.sv =====
interface hsfd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/hsfd_front.sv =====
module hsfd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hsfd_stream_if.sink    i_frame,
    input  logic           i_q_full,
    output logic           o_push,
    output hsfd_pkg::t_frame o_push_data
);
    import hsfd_pkg::*;

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic        r_t_ok;
    logic [15:0] r_raw_t;
    logic [15:0] r_raw_h;

    logic       w_accept;
    logic [2:0] w_pos;
    logic [7:0] w_crc_in;
    logic [7:0] w_byte;

    assign i_frame.ready = !i_q_full;
    assign w_accept      = i_frame.valid && !i_q_full;
    assign w_byte        = i_frame.data.rx_byte;

    // restart on frame start or on a position out of range
    assign w_pos    = (i_frame.data.frame_start || r_pos > POS_HUM_CRC) ? POS_TEMP_MSB : r_pos;
    assign w_crc_in = (w_pos == POS_TEMP_MSB || w_pos == POS_HUM_MSB) ? CRC_INIT : r_crc;

    always_comb begin
        n_pos = (w_pos == POS_HUM_CRC) ? POS_TEMP_MSB : w_pos + 3'd1;
        n_crc = crc8_byte(w_crc_in, w_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_TEMP_MSB;
        end else if (w_accept) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            unique case (w_pos)
                POS_TEMP_MSB: begin
                    r_raw_t[15:8] <= w_byte;
                    r_crc         <= n_crc;
                end
                POS_TEMP_LSB: begin
                    r_raw_t[7:0] <= w_byte;
                    r_crc        <= n_crc;
                end
                POS_TEMP_CRC: begin
                    r_t_ok <= (r_crc == w_byte);
                end
                POS_HUM_MSB: begin
                    r_raw_h[15:8] <= w_byte;
                    r_crc         <= n_crc;
                end
                POS_HUM_LSB: begin
                    r_raw_h[7:0] <= w_byte;
                    r_crc        <= n_crc;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_push = w_accept && (w_pos == POS_HUM_CRC);

    always_comb begin
        o_push_data.raw_t = r_raw_t;
        o_push_data.raw_h = r_raw_h;
        if (!r_t_ok) begin
            o_push_data.status = STATUS_TEMP_BAD;
        end else if (r_crc != w_byte) begin
            o_push_data.status = STATUS_HUM_BAD;
        end else begin
            o_push_data.status = STATUS_OK;
        end
    end

endmodule

// ===== rtl/core/hsfd_fifo.sv =====
module hsfd_fifo #(
    parameter int DEPTH = hsfd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hsfd_pkg::t_frame i_push_data,
    output logic             o_full,
    output logic             o_pop_valid,
    output hsfd_pkg::t_frame o_pop_data,
    input  logic             i_pop
);
    import hsfd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_frame        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_full      = (r_count == CW'(DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_data  = r_mem[r_rd_ptr];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/hsfd_back.sv =====
module hsfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  hsfd_pkg::t_frame i_q_data,
    output logic             o_q_pop,
    hsfd_stream_if.source    o_result
);
    import hsfd_pkg::*;

    // stage 1: scaled products
    logic        r_s1_valid;
    logic [30:0] r_s1_prod_t;
    logic [29:0] r_s1_prod_h;
    t_status     r_s1_status;

    // stage 2: output register
    logic r_out_valid;
    t_out r_out, n_out;

    logic        w_out_load;
    logic        w_s1_load;
    logic [31:0] w_sum_t;
    logic [30:0] w_sum_h;
    logic [14:0] w_q_t;
    logic [13:0] w_q_h;
    logic signed [15:0] w_temp;

    assign w_out_load = !r_out_valid || o_result.ready;
    assign w_s1_load  = !r_s1_valid || w_out_load;
    assign o_q_pop    = w_s1_load && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_prod_t <= 31'(i_q_data.raw_t) * 31'(TEMP_SPAN_CENTI);
            r_s1_prod_h <= 30'(i_q_data.raw_h) * 30'(HUM_SPAN_CENTI);
            r_s1_status <= i_q_data.status;
        end
    end

    // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for quotients below 65536
    assign w_sum_t = {1'b0, r_s1_prod_t} + {17'd0, r_s1_prod_t[30:16]} + 32'd1;
    assign w_sum_h = {1'b0, r_s1_prod_h} + {17'd0, r_s1_prod_h[29:16]} + 31'd1;
    assign w_q_t   = w_sum_t[30:16];
    assign w_q_h   = w_sum_h[29:16];
    assign w_temp  = signed'({1'b0, w_q_t}) - TEMP_OFFSET_CENTI;

    always_comb begin
        n_out.frame_status      = r_s1_status;
        n_out.temperature_centi = (r_s1_status == STATUS_TEMP_BAD) ? '0 : w_temp[14:0];
        n_out.humidity_centi    = (r_s1_status == STATUS_OK) ? w_q_h : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_load) begin
                r_s1_valid <= i_q_valid;
            end
            if (w_out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

endmodule

// ===== rtl/core/humidity_sensor_frame_decoder.sv =====
// Humidity sensor frame decoder.
// Input channel i_frame carries one word per handshake: a received byte and a
// frame-start flag. Six words make a frame: temperature high, low, CRC-8, then
// humidity high, low, CRC-8 (poly 0x31, init 0xFF). Frame start restarts the
// count; a partial frame is dropped without a result.
// Output channel o_result carries one word per complete frame: temperature and
// humidity in hundredths plus a status (temperature CRC bad, humidity CRC bad).
// Throughput: one input word per cycle while the queue is not full. The front
// checks CRCs on the fly, one byte per cycle through the CRC unit, and pushes
// finished frames into a short queue; the back scales them in a two-stage
// multiply / reciprocal pipeline (product register, then output register).
// Stall: when o_result.ready is low the output register holds its word; the
// back pipeline and then the queue fill, and i_frame.ready drops only when the
// queue is full. Bytes of a frame in progress keep flowing until then.
// Reset (synchronous, active low) empties the queue and pipeline and sets the
// byte count to the first position; no clearing pass is needed.
module humidity_sensor_frame_decoder #(
    parameter int QUEUE_DEPTH = hsfd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hsfd_stream_if.sink   i_frame,
    hsfd_stream_if.source o_result
);
    import hsfd_pkg::*;

    // front -> queue
    logic   w_push;
    t_frame w_push_data;
    logic   w_q_full;

    // queue -> back
    logic   w_q_valid;
    t_frame w_q_data;
    logic   w_q_pop;

    // Classify each byte, run the CRC, emit a frame record on the sixth byte
    hsfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (i_frame),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Decouple byte intake from a stalled receiver
    hsfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_q_full),
        .o_pop_valid (w_q_valid),
        .o_pop_data  (w_q_data),
        .i_pop       (w_q_pop)
    );

    // Scale raw readings to hundredths and drive the result register
    hsfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_q_pop),
        .o_result  (o_result)
    );

endmodule

// ===== tb/humidity_sensor_frame_decoder_test.sv =====
module humidity_sensor_frame_decoder_test;

    import hsfd_pkg::*;

    // Random words after the directed table; no word count is checked at the end.
    localparam int RANDOM_WORDS   = 1300;
    // Cycles with no word moving on either channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 1000;
    // Settle time after the last reading.
    localparam int SETTLE_CYCLES  = 10;

    localparam int unsigned RAW_FULL_SCALE = 65535;
    localparam int unsigned TEMP_SPAN      = 17500;
    localparam int unsigned HUM_SPAN       = 10000;
    localparam int          TEMP_OFFSET    = 4500;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hsfd_stream_if #(.T(t_in))  frame_if ();
    hsfd_stream_if #(.T(t_out)) result_if ();

    humidity_sensor_frame_decoder u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_if.sink),
        .o_result (result_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Directed table: one row per byte. Rows that close a frame and whose
    // reading is obvious carry it typed in; all other rows lean on the
    // frame predictor below.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0]         rx;
        logic               start;
        logic               typed;
        logic signed [14:0] temp;
        logic [13:0]        hum;
        t_status            status;
    } t_directed_row;

    localparam int DIRECTED_WORDS = 26;

    localparam t_directed_row DIRECTED_ROWS [DIRECTED_WORDS] = '{
        // all-zero frame right after reset: coldest, driest, both CRCs good
        '{8'h00, 1'b1, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'h00, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'h81, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'h00, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'h00, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'h81, 1'b0, 1'b1, -15'sd4500, 14'd0, STATUS_OK},
        // full-scale frame with no start flag: the count must wrap by itself
        '{8'hFF, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'hAC, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'hAC, 1'b0, 1'b1, 15'sd13000, 14'd10000, STATUS_OK},
        // temperature CRC bad, humidity CRC bad too: only the first counts
        '{8'h00, 1'b1, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'h00, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'h00, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'h00, 1'b0, 1'b1, 15'sd0, 14'd0, STATUS_TEMP_BAD},
        // two bytes of a frame, then a new start drops them
        '{8'hBE, 1'b1, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'hEF, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        // good temperature, humidity CRC bad: humidity reads zero
        '{8'h00, 1'b1, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'h00, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'h81, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, 15'sd0, 14'd0, STATUS_OK},
        '{8'h00, 1'b0, 1'b1, -15'sd4500, 14'd0, STATUS_HUM_BAD}
    };

    // ------------------------------------------------------------------
    // Frame predictor state: next byte position and the five held bytes.
    // ------------------------------------------------------------------
    logic [2:0] frame_pos;
    logic [7:0] held_bytes [5];

    t_out pending_readings [$];

    // Typed-in reading for the word now on the input channel, if any.
    bit   typed_pending;
    t_out typed_reading;

    int mismatches;
    int words_sent;
    int readings_checked;
    int temp_crc_errors;
    int hum_crc_errors;
    int stalled_cycles;
    int burst_left;

    // CRC-8 over a 16-bit word, MSB first, no reflection, no final xor.
    function automatic logic [7:0] sensor_crc8(input logic [15:0] word16);
        logic [7:0] crc;
        crc = CRC_INIT;
        for (int i = 15; i >= 0; i--) begin
            if (crc[7] ^ word16[i]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

    // Advance the predictor by one accepted word; return 1 when it closes a frame.
    function automatic bit decode_frame_byte(input t_in w, output t_out reading);
        logic [2:0]  slot;
        logic [15:0] raw_t;
        logic [15:0] raw_h;
        int          temp_c;
        int          hum_c;
        reading = '0;
        slot = (w.frame_start || frame_pos > POS_HUM_CRC) ? POS_TEMP_MSB : frame_pos;
        if (slot != POS_HUM_CRC) begin
            held_bytes[slot] = w.rx_byte;
            frame_pos = slot + 3'd1;
            return 1'b0;
        end
        frame_pos = POS_TEMP_MSB;
        raw_t = {held_bytes[POS_TEMP_MSB], held_bytes[POS_TEMP_LSB]};
        raw_h = {held_bytes[POS_HUM_MSB], held_bytes[POS_HUM_LSB]};
        if (sensor_crc8(raw_t) != held_bytes[POS_TEMP_CRC]) begin
            // bad temperature: both values stay zero, humidity CRC not judged
            reading.frame_status = STATUS_TEMP_BAD;
        end else begin
            temp_c = int'(longint'(raw_t) * TEMP_SPAN / RAW_FULL_SCALE) - TEMP_OFFSET;
            reading.temperature_centi = temp_c[14:0];
            if (sensor_crc8(raw_h) != w.rx_byte) begin
                reading.frame_status = STATUS_HUM_BAD;
            end else begin
                hum_c = int'(longint'(raw_h) * HUM_SPAN / RAW_FULL_SCALE);
                reading.humidity_centi = hum_c[13:0];
                reading.frame_status   = STATUS_OK;
            end
        end
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted input word, check every accepted
    // reading against the oldest expectation, and count idle cycles.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out predicted;
        t_out got;
        t_out want;
        if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles = stalled_cycles + 1;
        end
        if (i_rst_n && frame_if.valid && frame_if.ready) begin
            if (decode_frame_byte(frame_if.data, predicted)) begin
                pending_readings.push_back(typed_pending ? typed_reading : predicted);
            end
        end
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got = result_if.data;
            if (pending_readings.size() == 0) begin
                flag_mismatch($sformatf("reading with none expected: temp %0d hum %0d status %0d",
                                        $signed(got.temperature_centi), got.humidity_centi,
                                        got.frame_status));
            end else begin
                want = pending_readings.pop_front();
                readings_checked++;
                if (want.frame_status == STATUS_TEMP_BAD) temp_crc_errors++;
                if (want.frame_status == STATUS_HUM_BAD)  hum_crc_errors++;
                if (got.temperature_centi !== want.temperature_centi) begin
                    flag_mismatch($sformatf("temperature_centi got %0d expected %0d",
                                            $signed(got.temperature_centi),
                                            $signed(want.temperature_centi)));
                end
                if (got.humidity_centi !== want.humidity_centi) begin
                    flag_mismatch($sformatf("humidity_centi got %0d expected %0d",
                                            got.humidity_centi, want.humidity_centi));
                end
                if (got.frame_status !== want.frame_status) begin
                    flag_mismatch($sformatf("frame_status got %0d expected %0d",
                                            got.frame_status, want.frame_status));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: rotate a 32-bit ready pattern, picking a fresh one after every
    // two full rotations: always ready, coin flips, or mostly stalled. Bit 0 is
    // forced on in the stalled mode so no stall outlasts one rotation.
    // ------------------------------------------------------------------
    logic [31:0] ready_pattern = '1;
    int          pattern_age   = 0;

    always @(negedge i_clk) begin
        if (pattern_age == 0) begin
            case ($urandom_range(0, 2))
                0:       ready_pattern = '1;
                1:       ready_pattern = $urandom;
                default: ready_pattern = ($urandom & $urandom & $urandom) | 32'd1;
            endcase
            pattern_age = 64;
        end
        result_if.ready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
        pattern_age--;
    end

    // ------------------------------------------------------------------
    // Sender tasks. Drive at the falling edge, wait for the handshake at
    // the rising edge; valid stays high across back-to-back words.
    // ------------------------------------------------------------------
    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            frame_if.valid <= 1'b0;
            frame_if.data  <= 9'($urandom);
        end
    endtask

    // Burst pacing: short bursts with gaps, now and then a long unbroken run.
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle_sender($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 20);
        end
    endtask

    task automatic send_word(input t_in w, input bit typed, input t_out want);
        @(negedge i_clk);
        frame_if.valid <= 1'b1;
        frame_if.data  <= w;
        typed_pending  = typed;
        typed_reading  = want;
        do @(posedge i_clk); while (!(frame_if.valid && frame_if.ready));
        words_sent++;
        pace_sender();
    endtask

    task automatic send_byte(input logic [7:0] b, input bit start);
        t_in w;
        w.rx_byte     = b;
        w.frame_start = start;
        send_word(w, 1'b0, '0);
    endtask

    // Send the first byte_count bytes of a frame, corrupting CRCs on request.
    task automatic send_frame(input logic [15:0] raw_t, input logic [15:0] raw_h,
                              input bit with_start, input bit bad_t, input bit bad_h,
                              input int byte_count);
        logic [7:0] crc_t;
        logic [7:0] crc_h;
        logic [7:0] frame [6];
        crc_t = sensor_crc8(raw_t) ^ (bad_t ? 8'($urandom_range(1, 255)) : 8'd0);
        crc_h = sensor_crc8(raw_h) ^ (bad_h ? 8'($urandom_range(1, 255)) : 8'd0);
        frame = '{raw_t[15:8], raw_t[7:0], crc_t, raw_h[15:8], raw_h[7:0], crc_h};
        for (int k = 0; k < byte_count; k++) begin
            send_byte(frame[k], with_start && k == 0);
        end
    endtask

    // Hold valid low until every expected reading has come back.
    task automatic wait_for_drain();
        do idle_sender(1); while (pending_readings.size() != 0);
    endtask

    // Raw values lean toward the ends of the scale.
    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 15));
            3:       return 16'hFFFF - 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long.
    // ------------------------------------------------------------------
    initial begin
        do @(negedge i_clk); while (stalled_cycles < WATCHDOG_LIMIT);
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random frames, drain, verdict.
    // ------------------------------------------------------------------
    initial begin
        t_in           w;
        t_out          want;
        t_directed_row row;
        int            pick;
        int            frames_since_drain;
        frame_if.valid  = 1'b0;
        frame_if.data   = '0;
        result_if.ready = 1'b0;
        typed_pending   = 1'b0;
        typed_reading   = '0;
        frame_pos       = POS_TEMP_MSB;
        held_bytes      = '{default: 8'h00};
        frames_since_drain = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_WORDS; r++) begin
            row = DIRECTED_ROWS[r];
            w.rx_byte              = row.rx;
            w.frame_start          = row.start;
            want.temperature_centi = row.temp;
            want.humidity_centi    = row.hum;
            want.frame_status      = row.status;
            send_word(w, row.typed, want);
        end
        wait_for_drain();

        // Mostly well-formed frames with random content; the rest truncated
        // frames and loose noise bytes that knock the count out of line.
        while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                send_frame(pick_raw(), pick_raw(), $urandom_range(0, 9) != 0,
                           $urandom_range(0, 6) == 0, $urandom_range(0, 6) == 0, 6);
            end else if (pick < 90) begin
                send_frame(pick_raw(), pick_raw(), 1'b1, 1'b0, 1'b0, $urandom_range(1, 5));
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
            frames_since_drain++;
            if (frames_since_drain == 40) begin
                wait_for_drain();
                frames_since_drain = 0;
            end
        end

        idle_sender(1);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("sent %0d frame words, checked %0d readings", words_sent, readings_checked);
        $display("readings with temperature CRC errors: %0d, humidity CRC errors: %0d",
                 temp_crc_errors, hum_crc_errors);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/hsfd_pkg.sv
rtl/core/hsfd_stream_if.sv
rtl/core/hsfd_front.sv
rtl/core/hsfd_fifo.sv
rtl/core/hsfd_back.sv
rtl/core/humidity_sensor_frame_decoder.sv
tb/humidity_sensor_frame_decoder_test.sv
